@@ hdl/selms_pkg.sv @@
// Shared constants, types and controller state for the sign-error LMS noise canceller.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package selms_pkg;

    localparam int TAPS      = 16;
    localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SAMPLE_W  = 13;
    localparam int WEIGHT_W  = 32;
    localparam int STEP_W    = 16;
    localparam int LEVEL_W   = 12;
    localparam int PROD_W    = WEIGHT_W + SAMPLE_W;
    localparam int SHIFT     = 8;
    localparam int TERM_W    = PROD_W - SHIFT;
    localparam int ACC_W     = TERM_W + TAP_W + 2;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [STEP_W-1:0]  STEP_RESET       = 16'd1;
    localparam logic [LEVEL_W-1:0] ZERO_LEVEL_RESET = 12'd1850;
    localparam logic [LEVEL_W-1:0] OUT_MAX          = 12'd4095;

    localparam logic REG_STEP_SIZE  = 1'b0;
    localparam logic REG_ZERO_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             load;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic is_ref;
    } status_t;

endpackage

@@ hdl/sign_error_lms_noise_canceller.sv @@
// Reference item: accepted in IDLE, one multiply per tap in RUN, then DRAIN; DONE loads the
// registered anti_noise, waiting while a result is pending and out_ready is low.
// Error item: RUN and DRAIN through the shared multiplier with no result, or skipped in IDLE
// when equal to zero_level. Items are taken only in IDLE; one tap per cycle in RUN.
// Reset (rst_n low, asynchronous): delay line, weights and pointer cleared, step_size = 1,
// zero_level = 1850, no result pending.
`timescale 1ns / 1ps

module sign_error_lms_noise_canceller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic signed [selms_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [selms_pkg::LEVEL_W-1:0]        anti_noise,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [selms_pkg::ADDR_W-1:0]         paddr,
    input  logic [selms_pkg::DATA_W-1:0]         pwdata,
    output logic [selms_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);

    selms_pkg::cmd_t                  cmd;
    selms_pkg::status_t               status;
    logic [selms_pkg::STEP_W-1:0]     step_size_reg;
    logic [selms_pkg::LEVEL_W-1:0]    zero_level_reg;
    logic                             wr_en;
    logic                             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= selms_pkg::STEP_RESET;
            zero_level_reg <= selms_pkg::ZERO_LEVEL_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                selms_pkg::REG_STEP_SIZE:  step_size_reg  <= pwdata[selms_pkg::STEP_W-1:0];
                selms_pkg::REG_ZERO_LEVEL: zero_level_reg <= pwdata[selms_pkg::LEVEL_W-1:0];
                default:                   step_size_reg  <= step_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            selms_pkg::REG_STEP_SIZE:
                prdata = {{(selms_pkg::DATA_W - selms_pkg::STEP_W){1'b0}}, step_size_reg};
            selms_pkg::REG_ZERO_LEVEL:
                prdata = {{(selms_pkg::DATA_W - selms_pkg::LEVEL_W){1'b0}}, zero_level_reg};
            default:
                prdata = '0;
        endcase
    end

    selms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    selms_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .sample     (sample),
        .step_size  (step_size_reg),
        .zero_level (zero_level_reg),
        .anti_noise (anti_noise)
    );

endmodule

@@ hdl/selms_ctrl.sv @@
// Controller state machine: sequences item transfer, tap iteration and result hand-off.
// Depends on selms_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps

module selms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  selms_pkg::status_t status,
    output selms_pkg::cmd_t    cmd
);

    selms_pkg::state_t              state_reg, state_next;
    logic [selms_pkg::TAP_W-1:0]    tap_reg, tap_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           last_tap;

    assign last_tap = (tap_reg == selms_pkg::TAP_W'(selms_pkg::TAPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            selms_pkg::ST_IDLE:
            begin
                if (in_valid && !status.skip)
                begin
                    state_next = selms_pkg::ST_RUN;
                end
            end
            selms_pkg::ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = selms_pkg::ST_DRAIN;
                end
            end
            selms_pkg::ST_DRAIN:
            begin
                state_next = status.is_ref ? selms_pkg::ST_DONE : selms_pkg::ST_IDLE;
            end
            selms_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = selms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = selms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.issue    = 1'b0;
        cmd.tap      = tap_reg;
        cmd.out_load = 1'b0;
        tap_next     = tap_reg;
        unique case (state_reg)
            selms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                tap_next = '0;
            end
            selms_pkg::ST_RUN:
            begin
                cmd.issue = 1'b1;
                tap_next  = last_tap ? '0 : tap_reg + 1'b1;
            end
            selms_pkg::ST_DRAIN:
            begin
                tap_next = '0;
            end
            selms_pkg::ST_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                tap_next = '0;
            end
        endcase
    end

    // hold the result until the downstream transfer completes
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= selms_pkg::ST_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/selms_datapath.sv @@
// Datapath: delay line, tap weights, shared multiplier and accumulator, output register.
// Depends on selms_pkg; driven by selms_ctrl through cmd_t and reports through status_t.
`timescale 1ns / 1ps

module selms_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  selms_pkg::cmd_t                      cmd,
    output selms_pkg::status_t                   status,
    input  logic                                 mode,
    input  logic signed [selms_pkg::SAMPLE_W-1:0] sample,
    input  logic [selms_pkg::STEP_W-1:0]         step_size,
    input  logic [selms_pkg::LEVEL_W-1:0]        zero_level,
    output logic [selms_pkg::LEVEL_W-1:0]        anti_noise
);

    logic signed [selms_pkg::SAMPLE_W-1:0] line_reg [selms_pkg::TAPS];
    logic signed [selms_pkg::WEIGHT_W-1:0] weight_reg [selms_pkg::TAPS];
    logic [selms_pkg::TAP_W-1:0]           newest_reg, newest_next;
    logic [selms_pkg::TAP_W-1:0]           pos_reg;
    logic                                  mode_reg;
    logic                                  up_reg;
    logic                                  pvalid_reg;
    logic [selms_pkg::TAP_W-1:0]           ptap_reg;
    logic signed [selms_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [selms_pkg::ACC_W-1:0]    acc_reg;
    logic [selms_pkg::LEVEL_W-1:0]         anti_noise_reg;
    logic signed [selms_pkg::WEIGHT_W-1:0] mul_a;
    logic signed [selms_pkg::SAMPLE_W:0]   level_s;
    logic signed [selms_pkg::TERM_W-1:0]   term;
    logic signed [selms_pkg::WEIGHT_W-1:0] delta;
    logic signed [selms_pkg::WEIGHT_W-1:0] w_cur;
    logic [selms_pkg::LEVEL_W-1:0]         sat;

    assign level_s     = $signed({2'b00, zero_level});
    assign status.skip = mode && ($signed({sample[selms_pkg::SAMPLE_W-1], sample}) == level_s);
    assign status.is_ref = !mode_reg;

    assign newest_next = (newest_reg == '0) ? selms_pkg::TAP_W'(selms_pkg::TAPS - 1)
                                            : newest_reg - 1'b1;

    // one multiplier: weight times sample for the filter, step times sample for adaptation
    assign mul_a = mode_reg
                 ? $signed({{(selms_pkg::WEIGHT_W - selms_pkg::STEP_W){1'b0}}, step_size})
                 : weight_reg[cmd.tap];
    assign prod_next = mul_a * line_reg[pos_reg];

    assign term  = prod_reg[selms_pkg::PROD_W-1:selms_pkg::SHIFT];
    assign delta = prod_reg[selms_pkg::WEIGHT_W-1:0];
    assign w_cur = weight_reg[ptap_reg];

    always_comb
    begin
        priority if (acc_reg < 0)
        begin
            sat = '0;
        end
        else if (acc_reg > $signed({{(selms_pkg::ACC_W - selms_pkg::LEVEL_W){1'b0}},
                                    selms_pkg::OUT_MAX}))
        begin
            sat = selms_pkg::OUT_MAX;
        end
        else
        begin
            sat = acc_reg[selms_pkg::LEVEL_W-1:0];
        end
    end

    assign anti_noise = anti_noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < selms_pkg::TAPS; i++)
            begin
                line_reg[i]   <= '0;
                weight_reg[i] <= '0;
            end
            newest_reg <= '0;
            pos_reg    <= '0;
            mode_reg   <= 1'b0;
            up_reg     <= 1'b0;
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= cmd.issue;
            if (cmd.load)
            begin
                mode_reg <= mode;
                up_reg   <= $signed({sample[selms_pkg::SAMPLE_W-1], sample}) > level_s;
                if (!mode)
                begin
                    // push: newest sample goes one slot before the old newest
                    newest_reg           <= newest_next;
                    pos_reg              <= newest_next;
                    line_reg[newest_next] <= sample;
                end
                else
                begin
                    pos_reg <= newest_reg;
                end
            end
            else if (cmd.issue)
            begin
                pos_reg <= (pos_reg == selms_pkg::TAP_W'(selms_pkg::TAPS - 1))
                         ? '0 : pos_reg + 1'b1;
            end
            if (pvalid_reg && mode_reg)
            begin
                weight_reg[ptap_reg] <= up_reg ? w_cur + delta : w_cur - delta;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        ptap_reg <= cmd.tap;
        if (cmd.load)
        begin
            acc_reg <= $signed({{(selms_pkg::ACC_W - selms_pkg::LEVEL_W){1'b0}}, zero_level});
        end
        else if (pvalid_reg && !mode_reg)
        begin
            acc_reg <= acc_reg + {{(selms_pkg::ACC_W - selms_pkg::TERM_W){term[selms_pkg::TERM_W-1]}},
                                  term};
        end
        if (cmd.out_load)
        begin
            anti_noise_reg <= sat;
        end
    end

endmodule
